// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the pixel store; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_AFTER(name, clk, rst, a, n, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(name, clk, rst, a, b)
`define ASSERT_AFTER(name, clk, rst, a, n, b)
`endif
`endif

// ===== sv/dtps_pkg.sv =====
// ----------------------------------------------------------------------------
// dtps_pkg
// Shared types and constants of the depth-tested pixel store.
// ----------------------------------------------------------------------------
package dtps_pkg;

  localparam int CFG_W           = 10;
  localparam int IDX_W           = 2 * CFG_W;
  localparam int PADDR_W         = 3;
  localparam int MAX_WIDTH_DEF   = 512;
  localparam int MAX_HEIGHT_DEF  = 512;
  localparam int DEPTH_BITS_DEF  = 24;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PLOT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic REG_WIDTH_SEL  = 1'b0;
  localparam logic REG_HEIGHT_SEL = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [23:0]        depth_in;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
  } item_t;

  typedef struct packed {
    logic        in_frame;
    logic        written;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [23:0] depth_out;
  } result_t;

  // in_frame of a clear entry flags a non-empty frame; idx then holds the last pixel
  typedef struct packed {
    logic [1:0]       opcode;
    logic             in_frame;
    logic [IDX_W-1:0] idx;
    logic [23:0]      depth_in;
    logic [23:0]      colour;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic idle;
    logic clearing;
  } back_stat_t;

endpackage

// ===== sv/dtps_front.sv =====
// ----------------------------------------------------------------------------
// dtps_front
// Frame registers, command intake, bounds check and pixel index.
// ----------------------------------------------------------------------------
module dtps_front #(
  parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  input  dtps_pkg::item_t              item,
  output logic                         busy,
  input  dtps_pkg::fifo_stat_t         fifo_stat,
  output logic                         push,
  output dtps_pkg::entry_t             entry
);
  import dtps_pkg::*;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic             x_ok;
  logic             y_ok;
  logic             is_clear;
  logic [IDX_W-1:0] mul_a;
  logic [IDX_W-1:0] prod;
  logic [IDX_W-1:0] addend;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_RESET;
      frame_height <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH_SEL:  frame_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT_SEL: frame_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH_SEL:  prdata = 32'(frame_width);
      REG_HEIGHT_SEL: prdata = 32'(frame_height);
      default:        prdata = '0;
    endcase
  end

  // saturate to the store size
  assign w_eff = (32'(frame_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : frame_width;
  assign h_eff = (32'(frame_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : frame_height;

  assign x_ok = !item.pos_x[15] && (15'(w_eff) > item.pos_x[14:0]);
  assign y_ok = !item.pos_y[15] && (15'(h_eff) > item.pos_y[14:0]);

  // one multiplier: y*w+x for a pixel, h*w-1 for a clear
  assign is_clear = (item.opcode == OP_CLEAR);
  assign mul_a    = is_clear ? IDX_W'(h_eff) : IDX_W'(item.pos_y[CFG_W-1:0]);
  assign prod     = mul_a * IDX_W'(w_eff);
  assign addend   = is_clear ? '1 : IDX_W'(item.pos_x[CFG_W-1:0]);
  assign idx      = prod + addend;

  assign busy = fifo_stat.full;
  assign push = start && !fifo_stat.full;

  always_comb begin
    entry.opcode   = item.opcode;
    entry.in_frame = is_clear ? (prod != '0) : (x_ok && y_ok);
    entry.idx      = idx;
    entry.depth_in = item.depth_in;
    entry.colour   = {item.red_in, item.green_in, item.blue_in};
  end

endmodule

// ===== sv/dtps_fifo.sv =====
// ----------------------------------------------------------------------------
// dtps_fifo
// Short command queue between intake and the store sequencer.
// ----------------------------------------------------------------------------
module dtps_fifo #(
  parameter int QUEUE_DEPTH = dtps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dtps_pkg::entry_t     push_entry,
  input  logic                 pop,
  output dtps_pkg::entry_t     head,
  output dtps_pkg::fifo_stat_t stat
);
  import dtps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/dtps_back.sv =====
// ----------------------------------------------------------------------------
// dtps_back
// Colour and depth stores, clear walk and read-test-write of one pixel.
// ----------------------------------------------------------------------------
module dtps_back #(
  parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtps_pkg::DEPTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dtps_pkg::fifo_stat_t fifo_stat,
  input  dtps_pkg::entry_t     head,
  output logic                 pop,
  output dtps_pkg::back_stat_t stat,
  output logic                 done,
  output dtps_pkg::result_t    result
);
  import dtps_pkg::*;

  localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLEAR = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [23:0]           colour_mem [STORE];
  logic [DEPTH_BITS-1:0] depth_mem  [STORE];

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [ADDR_W-1:0]     clear_cursor;
  entry_t                cur;
  logic [23:0]           col_q;
  logic [DEPTH_BITS-1:0] dep_q;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     cur_addr;
  logic [ADDR_W-1:0]     last_addr;
  logic [DEPTH_BITS-1:0] new_depth;
  logic                  hit;
  logic                  pass;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [23:0]           wcol;
  logic [DEPTH_BITS-1:0] wdep;
  result_t               res_next;

  assign pop        = (state == S_IDLE) && !fifo_stat.empty;
  assign raddr      = ADDR_W'(head.idx);
  assign cur_addr   = ADDR_W'(cur.idx);
  assign last_addr  = ADDR_W'(cur.idx);
  assign new_depth  = DEPTH_BITS'(cur.depth_in);
  assign hit        = cur.in_frame && ((cur.opcode == OP_PLOT) || (cur.opcode == OP_READ));
  assign pass       = (state == S_EXEC) && hit && (cur.opcode == OP_PLOT) &&
                      (new_depth < dep_q);
  assign stat.idle     = (state == S_IDLE);
  assign stat.clearing = (state == S_CLEAR);

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wcol  = cur.colour;
    wdep  = new_depth;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clear_cursor;
      wdep  = '1;
    end else if (pass) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      colour_mem[waddr] <= wcol;
      depth_mem[waddr]  <= wdep;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      col_q <= colour_mem[raddr];
      dep_q <= depth_mem[raddr];
      cur   <= head;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          state_next = ((head.opcode == OP_CLEAR) && head.in_frame) ? S_CLEAR : S_EXEC;
        end
      end
      S_CLEAR: begin
        if (clear_cursor == last_addr) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_next           = '0;
    res_next.in_frame  = hit;
    res_next.written   = pass;
    if (hit && (cur.opcode == OP_READ)) begin
      res_next.red_out   = col_q[23:16];
      res_next.green_out = col_q[15:8];
      res_next.blue_out  = col_q[7:0];
      res_next.depth_out = 24'(dep_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      clear_cursor <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (state == S_CLEAR) begin
        clear_cursor <= (clear_cursor == last_addr) ? '0 : clear_cursor + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      result <= res_next;
    end
  end

endmodule

// ===== sv/depth_tested_pixel_store.sv =====
// ----------------------------------------------------------------------------
// depth_tested_pixel_store
// Z-buffered frame store: clear, depth-tested plot and pixel read.
// ----------------------------------------------------------------------------
// A plot or a read occupies the store sequencer for one registered memory
// read, then the depth test and write; a clear writes every pixel of the
// frame, one pixel written per cycle. Commands wait in a QUEUE_DEPTH-entry
// queue, so start is taken while the store works; busy is high only while
// that queue is full. Each command gives one result, shown for a single
// cycle with done; the receiver cannot stall it. Stores are not initialized
// at reset: issue a clear before any plot or read. Frame registers must be
// written only while no command is outstanding; the block does not enforce it.
`include "assert_macros.svh"

module depth_tested_pixel_store #(
  parameter int MAX_WIDTH   = dtps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = dtps_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS  = dtps_pkg::DEPTH_BITS_DEF,
  parameter int QUEUE_DEPTH = dtps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dtps_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         start,
  input  dtps_pkg::item_t              item,
  output logic                         busy,
  output logic                         done,
  output dtps_pkg::result_t            result
);
  import dtps_pkg::*;

  fifo_stat_t fifo_stat;
  back_stat_t back_stat;
  entry_t     push_entry;
  entry_t     head;
  logic       push;
  logic       pop;

  dtps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .fifo_stat (fifo_stat),
    .push      (push),
    .entry     (push_entry)
  );

  dtps_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_stat)
  );

  dtps_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_stat (fifo_stat),
    .head      (head),
    .pop       (pop),
    .stat      (back_stat),
    .done      (done),
    .result    (result)
  );

  // results never come back to back
  `ASSERT_AFTER(a_done_spacing, clk, rst, done, 1, !done)
  // a plot or read into an idle block passes the queue, the memory read and the execute state before done
  `ASSERT_AFTER(a_latency, clk, rst, start && !busy && fifo_stat.empty && back_stat.idle && item.opcode != OP_CLEAR, 3, done)
  // only an in-frame plot can write
  `ASSERT_IMPLY(a_write_in_frame, clk, rst, done && result.written, result.in_frame)
  // a clear walk never overlaps a result
  `ASSERT_IMPLY(a_clear_quiet, clk, rst, back_stat.clearing && $past(back_stat.clearing), !done)

endmodule

// ===== tb/depth_tested_pixel_store_tb.sv =====
// ----------------------------------------------------------------------------
// depth_tested_pixel_store_tb
// Self-checking bench for the z-buffered pixel store. Commands are predicted
// against a local copy of the colour and depth stores at the moment their
// transfer is taken, and each done strobe is checked field by field against
// the oldest prediction. A directed run on the reset frame is followed by
// random phases over frame sizes from empty through saturated, with random
// sender gaps and a full drain before every frame register write.
// ----------------------------------------------------------------------------
module depth_tested_pixel_store_tb;
  import dtps_pkg::*;

  localparam int          STORE_SIZE     = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam logic [23:0] DEPTH_FAR      = 24'hFFFFFF;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int          STALL_LIMIT    = 800_000;
  localparam int          RAND_PER_PHASE = 85;
  localparam int          CLEAR_MAX_PIX  = 4096;
  localparam int          N_FIXED        = 8;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start   = 1'b0;
  item_t              item    = '0;
  logic               busy;
  logic               done;
  result_t            result;

  depth_tested_pixel_store u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // frame registers and stores as seen by the predictor
  logic [CFG_W-1:0] frame_w_reg = CFG_RESET;
  logic [CFG_W-1:0] frame_h_reg = CFG_RESET;
  logic [23:0]      pixel_colour [STORE_SIZE];
  logic [23:0]      pixel_depth  [STORE_SIZE];

  item_t   commands_pending [$];
  result_t expected_results [$];
  int      fail_cnt     = 0;
  int      gap_left     = 0;
  int      stall_cycles = 0;
  bit      burst        = 1'b0;

  function automatic int used_cols();
    return (frame_w_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(frame_w_reg);
  endfunction

  function automatic int used_rows();
    return (frame_h_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(frame_h_reg);
  endfunction

  function automatic result_t exec_command(item_t c);
    result_t r;
    int      w;
    int      h;
    int      idx;
    bit      hit;
    r   = '0;
    w   = used_cols();
    h   = used_rows();
    hit = !c.pos_x[15] && !c.pos_y[15] && int'(c.pos_x) < w && int'(c.pos_y) < h;
    idx = int'(c.pos_y) * w + int'(c.pos_x);
    case (c.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < w * h; i++) begin
          pixel_colour[i] = {c.red_in, c.green_in, c.blue_in};
          pixel_depth[i]  = DEPTH_FAR;
        end
      end
      OP_PLOT: begin
        if (hit) begin
          r.in_frame = 1'b1;
          if (c.depth_in < pixel_depth[idx]) begin
            pixel_depth[idx]  = c.depth_in;
            pixel_colour[idx] = {c.red_in, c.green_in, c.blue_in};
            r.written         = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (hit) begin
          r.in_frame = 1'b1;
          {r.red_out, r.green_out, r.blue_out} = pixel_colour[idx];
          r.depth_out = pixel_depth[idx];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t cmd(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                logic [23:0] d, logic [23:0] rgb);
    item_t c;
    c.opcode   = op;
    c.pos_x    = x;
    c.pos_y    = y;
    c.depth_in = d;
    {c.red_in, c.green_in, c.blue_in} = rgb;
    return c;
  endfunction

  // in range: half the time near the origin so plots and reads collide
  function automatic logic [15:0] rand_coord(int lim, bit in_rng);
    if (in_rng) begin
      if ($urandom_range(0, 1) == 1)
        return 16'($urandom_range(0, ((lim < 4) ? lim : 4) - 1));
      return 16'($urandom_range(0, lim - 1));
    end
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(32768, 65535));
      1:       return 16'($urandom_range(lim, 32767));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t rand_command();
    item_t c;
    int    w;
    int    h;
    int    pick;
    bit    in_rng;
    w          = used_cols();
    h          = used_rows();
    c.red_in   = 8'($urandom);
    c.green_in = 8'($urandom);
    c.blue_in  = 8'($urandom);
    pick       = $urandom_range(0, 99);
    if (pick < 48)
      c.opcode = OP_PLOT;
    else if (pick < 84)
      c.opcode = OP_READ;
    else if (pick < 91)
      c.opcode = (w * h <= CLEAR_MAX_PIX) ? OP_CLEAR : OP_PLOT;
    else
      c.opcode = OP_UNUSED;
    in_rng = (w > 0 && h > 0 && $urandom_range(0, 9) < 8);
    if (in_rng) begin
      c.pos_x = rand_coord(w, 1'b1);
      c.pos_y = rand_coord(h, 1'b1);
    end else begin
      pick    = $urandom_range(0, 2);
      c.pos_x = rand_coord(w, pick == 0 && w > 0);
      c.pos_y = rand_coord(h, pick == 1 && h > 0);
    end
    case ($urandom_range(0, 5))
      0:       c.depth_in = '0;
      1:       c.depth_in = DEPTH_FAR;
      2:       c.depth_in = 24'($urandom_range(0, 255));
      3:       c.depth_in = DEPTH_FAR - 24'($urandom_range(1, 3));
      default: c.depth_in = 24'($urandom);
    endcase
    return c;
  endfunction

  task automatic frame_write(logic sel, logic [CFG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({sel, 2'b00});
    pwdata  <= {22'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_WIDTH_SEL)
      frame_w_reg = val;
    else
      frame_h_reg = val;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (commands_pending.size() != 0 || start || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // command driver
  always @(posedge clk) begin : drive
    logic take;
    int   wait_n;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      take   = start && !busy;
      wait_n = gap_left;
      if (take) begin
        expected_results.push_back(exec_command(item));
        if ($urandom_range(0, 39) == 0)
          burst = !burst;
        wait_n = burst ? 0 : $urandom_range(0, 14);
      end
      if (take || !start) begin
        if (wait_n == 0 && commands_pending.size() != 0) begin
          item  <= commands_pending.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
          if (wait_n > 0)
            gap_left <= wait_n - 1;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        check_field("in_frame",  want.in_frame,  result.in_frame);
        check_field("written",   want.written,   result.written);
        check_field("red_out",   want.red_out,   result.red_out);
        check_field("green_out", want.green_out, result.green_out);
        check_field("blue_out",  want.blue_out,  result.blue_out);
        check_field("depth_out", want.depth_out, result.depth_out);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int   phase_w [N_FIXED];
    int   phase_h [N_FIXED];
    int   w;
    int   h;
    item_t c;
    phase_w = '{1, 0, 7, 1023, 2, 512, 16, 5};
    phase_h = '{1, 5, 0, 1, 1023, 3, 9, 13};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset frame: corners, equal-depth rejects, out-of-frame and unused op
    commands_pending.push_back(cmd(OP_CLEAR, 16'h1234, 16'h5678, 24'h0, 24'hFF00A5));
    commands_pending.push_back(cmd(OP_READ, 16'd0, 16'd0, 24'hABCDEF, 24'h0));
    commands_pending.push_back(cmd(OP_READ, 16'd511, 16'd511, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_PLOT, 16'd511, 16'd511, DEPTH_FAR, 24'h123456));
    commands_pending.push_back(cmd(OP_PLOT, 16'd511, 16'd511, 24'hFFFFFE, 24'hFFFFFF));
    commands_pending.push_back(cmd(OP_PLOT, 16'd511, 16'd511, 24'hFFFFFE, 24'h00FF00));
    commands_pending.push_back(cmd(OP_READ, 16'd511, 16'd511, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_PLOT, 16'd511, 16'd511, 24'h0, 24'h000000));
    commands_pending.push_back(cmd(OP_PLOT, 16'd511, 16'd511, 24'h0, 24'h0000FF));
    commands_pending.push_back(cmd(OP_READ, 16'd511, 16'd511, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_PLOT, 16'd0, 16'd0, 24'h800000, 24'h5A5A5A));
    commands_pending.push_back(cmd(OP_PLOT, 16'd0, 16'd0, 24'h7FFFFF, 24'hA5A5A5));
    commands_pending.push_back(cmd(OP_READ, 16'd0, 16'd0, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_PLOT, 16'd512, 16'd0, 24'h0, 24'hFFFFFF));
    commands_pending.push_back(cmd(OP_READ, 16'd0, 16'd512, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_PLOT, 16'hFFFF, 16'd0, 24'h0, 24'h808080));
    commands_pending.push_back(cmd(OP_READ, 16'd0, 16'h8000, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_PLOT, 16'h7FFF, 16'h7FFF, 24'h0, 24'h010203));
    commands_pending.push_back(cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, DEPTH_FAR, 24'hFFFFFF));
    commands_pending.push_back(cmd(OP_READ, 16'd511, 16'd0, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_READ, 16'd0, 16'd511, 24'h0, 24'h0));
    commands_pending.push_back(cmd(OP_PLOT, 16'd300, 16'd200, 24'h000001, 24'hC0FFEE));
    commands_pending.push_back(cmd(OP_READ, 16'd300, 16'd200, 24'h0, 24'h0));
    repeat (60) commands_pending.push_back(rand_command());
    wait_drained();

    for (int p = 0; p < N_FIXED + 3; p++) begin
      if (p < N_FIXED) begin
        w = phase_w[p];
        h = phase_h[p];
      end else begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 24);
      end
      frame_write(REG_WIDTH_SEL, CFG_W'(w));
      frame_write(REG_HEIGHT_SEL, CFG_W'(h));
      c        = rand_command();
      c.opcode = OP_CLEAR;
      commands_pending.push_back(c);
      repeat (RAND_PER_PHASE) commands_pending.push_back(rand_command());
      wait_drained();
    end

    repeat (16) @(negedge clk);
    if (fail_cnt == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dtps_pkg.sv
sv/dtps_front.sv
sv/dtps_fifo.sv
sv/dtps_back.sv
sv/depth_tested_pixel_store.sv
tb/depth_tested_pixel_store_tb.sv
